@@ design/ltss_pkg.sv @@
// ----------------------------------------------------------------------------
// ltss_pkg
// Types, constants and the digit font shared by the lap time display blocks.
// ----------------------------------------------------------------------------
package ltss_pkg;

    localparam int LANE_W       = 3;
    localparam int TIME_W       = 32;
    localparam int LANE_COUNT   = 6;
    localparam int BIN_W        = 17;                 // covers every time below the limit
    localparam int BCD_DIGITS   = 5;
    localparam int BCD_W        = 4 * BCD_DIGITS;
    localparam int SEG_W        = 8;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [TIME_W-1:0] TIME_LIMIT  = 32'd100000;
    localparam logic [TIME_W-1:0] SHORT_LIMIT = 32'd10000;

    localparam logic [SEG_W-1:0] SEG_POINT = 8'h80;
    localparam logic [SEG_W-1:0] SEG_DASH  = 8'h40;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DP_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INVALID = 2'd1;

    // Payload carried down the conversion chain
    typedef struct packed {
        logic [LANE_W-1:0] lane;
        logic              dash;
        logic              short_fmt;
        logic              dp_mode;
        logic [BIN_W-1:0]  bits;
        logic [BCD_W-1:0]  bcd;
    } cell_data_t;

    function automatic logic [6:0] seg_font(input logic [3:0] d);
        logic [6:0] s;
        unique case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

@@ design/ltss_cell.sv @@
// ----------------------------------------------------------------------------
// ltss_cell
// One shift-and-add-3 step of the binary to BCD chain, with its own register.
// ----------------------------------------------------------------------------
module ltss_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ltss_pkg::cell_data_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ltss_pkg::cell_data_t out_data
);

    logic                 valid_reg;
    ltss_pkg::cell_data_t data_reg;
    ltss_pkg::cell_data_t data_next;
    logic [ltss_pkg::BCD_W-1:0] adj;

    assign in_ready = !valid_reg || out_ready;

    // adjust every digit of five or more, then shift in the next binary bit
    always_comb begin
        adj = in_data.bcd;
        for (int i = 0; i < ltss_pkg::BCD_DIGITS; i++) begin
            if (adj[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
            end
        end
        data_next      = in_data;
        data_next.bcd  = {adj[ltss_pkg::BCD_W-2:0], in_data.bits[ltss_pkg::BIN_W-1]};
        data_next.bits = {in_data.bits[ltss_pkg::BIN_W-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ design/ltss_out.sv @@
// ----------------------------------------------------------------------------
// ltss_out
// Segment encoder and output register for the finished BCD digits.
// ----------------------------------------------------------------------------
module ltss_out (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  ltss_pkg::cell_data_t         in_data,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [4*ltss_pkg::SEG_W-1:0] m_tdata,
    output logic [ltss_pkg::LANE_W-1:0]  m_tuser
);

    logic                              valid_reg;
    logic [4*ltss_pkg::SEG_W-1:0]      seg_reg;
    logic [4*ltss_pkg::SEG_W-1:0]      seg_next;
    logic [ltss_pkg::LANE_W-1:0]       lane_reg;
    logic [ltss_pkg::SEG_W-1:0]        d0, d1, d2, d3;

    assign in_ready = !valid_reg || m_tready;

    always_comb begin
        if (in_data.dash) begin
            d0 = ltss_pkg::SEG_DASH;
            d1 = ltss_pkg::SEG_DASH;
            d2 = ltss_pkg::SEG_DASH;
            d3 = ltss_pkg::SEG_DASH;
        end else if (in_data.short_fmt) begin
            d0 = {in_data.dp_mode, ltss_pkg::seg_font(in_data.bcd[15:12])};
            d1 = {1'b0, ltss_pkg::seg_font(in_data.bcd[11:8])};
            d2 = {1'b0, ltss_pkg::seg_font(in_data.bcd[7:4])};
            d3 = {1'b0, ltss_pkg::seg_font(in_data.bcd[3:0])};
        end else begin
            d0 = {!in_data.dp_mode, ltss_pkg::seg_font(in_data.bcd[19:16])};
            d1 = {1'b1, ltss_pkg::seg_font(in_data.bcd[15:12])};
            d2 = {1'b0, ltss_pkg::seg_font(in_data.bcd[11:8])};
            d3 = {1'b0, ltss_pkg::seg_font(in_data.bcd[7:4])};
        end
        seg_next = {d3, d2, d1, d0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            seg_reg  <= seg_next;
            lane_reg <= in_data.lane;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = seg_reg;
    assign m_tuser  = lane_reg;

endmodule

@@ design/lap_time_to_seven_segment_core.sv @@
// ----------------------------------------------------------------------------
// lap_time_to_seven_segment_core
// Lap time to four-digit seven-segment converter, one time per clock unless m_tready stalls.
// ----------------------------------------------------------------------------
// Input stream: s_tdata carries a time in milliseconds, s_tuser the display
// lane. A transfer whose lane is at or above LANE_COUNT is taken and dropped.
// Output stream: m_tdata carries four segment codes, leftmost digit in the
// lowest byte, m_tuser the lane they belong to.
// Times equal to the invalid marker, or of 100000 ms and more, show dashes;
// below 10000 ms the display reads S.mmm, otherwise SS.mm.
// The time is split into BCD digits by a chain of BIN_W shift-and-add-3
// cells, one binary bit per cell, followed by the segment output register;
// one transfer is taken every cycle unless m_tready stalls. Each stage holds
// its own item, so a stall on m_tready fills the empty stages before
// s_tready falls.
// Reset (aresetn low, synchronous) empties the chain, sets decimal point
// mode and sets the invalid marker to all ones.
// Configuration writes land on cfg_we; write only while the chain is empty.
// ----------------------------------------------------------------------------
module lap_time_to_seven_segment_core #(
    parameter int LANE_COUNT = ltss_pkg::LANE_COUNT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [ltss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ltss_pkg::TIME_W-1:0]       cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ltss_pkg::TIME_W-1:0]       s_tdata,   // [31:0] time_ms
    input  logic [ltss_pkg::LANE_W-1:0]       s_tuser,   // [2:0] lane
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [4*ltss_pkg::SEG_W-1:0]      m_tdata,   // [7:0] digit0_segments,
                                                         // [15:8] digit1_segments,
                                                         // [23:16] digit2_segments,
                                                         // [31:24] digit3_segments
    output logic [ltss_pkg::LANE_W-1:0]       m_tuser    // [2:0] lane_out
);

    localparam int N = ltss_pkg::BIN_W;
    localparam logic [ltss_pkg::LANE_W:0] LaneLimit = (ltss_pkg::LANE_W + 1)'(LANE_COUNT);

    // configuration registers
    logic                        dp_mode_reg;
    logic [ltss_pkg::TIME_W-1:0] marker_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dp_mode_reg <= 1'b1;
            marker_reg  <= '1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ltss_pkg::REG_DP_MODE: dp_mode_reg <= cfg_data[0];
                ltss_pkg::REG_INVALID: marker_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // chain links: index i feeds cell i, index N feeds the output stage
    logic                 link_valid [0:N];
    logic                 link_ready [0:N];
    ltss_pkg::cell_data_t link_data  [0:N];

    logic                 lane_ok;
    logic                 is_dash;
    ltss_pkg::cell_data_t entry_data;

    // classify at the entry; the cells only carry the flags along
    assign lane_ok = ({1'b0, s_tuser} < LaneLimit);
    assign is_dash = (s_tdata == marker_reg) || (s_tdata >= ltss_pkg::TIME_LIMIT);

    always_comb begin
        entry_data.lane      = s_tuser;
        entry_data.dash      = is_dash;
        entry_data.short_fmt = (s_tdata < ltss_pkg::SHORT_LIMIT);
        entry_data.dp_mode   = dp_mode_reg;
        entry_data.bits      = is_dash ? '0 : s_tdata[N-1:0];
        entry_data.bcd       = '0;
    end

    assign link_data[0] = entry_data;

    // drop out-of-range lanes: take the transfer, insert nothing
    assign link_valid[0] = s_tvalid && lane_ok;
    assign s_tready      = link_ready[0];

    for (genvar i = 0; i < N; i++) begin : g_cell
        ltss_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_data   (link_data[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_data  (link_data[i+1])
        );
    end

    ltss_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (link_valid[N]),
        .in_ready (link_ready[N]),
        .in_data  (link_data[N]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // an in-range transfer always enters the first cell
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && lane_ok) |=> link_valid[1])
        else $error("accepted item did not enter the chain");

    // dropped lanes never reach the output
    a_lane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tuser} < LaneLimit))
        else $error("out-of-range lane on result stream");

    // the two rightmost digits never carry a separator
    a_sep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[23] && !m_tdata[31]))
        else $error("separator lit on digit 2 or 3");

endmodule
